[rtl/str_pkg.sv]
package str_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [16:0] FRAC_ONE = 17'h10000;
    localparam logic [15:0] Q88_ONE = 16'd256;

    localparam int NUM_W = 64;
    localparam int DEN_W = 45;
    localparam int RDIV_NB = 49;
    localparam int RDIV_DW = 17;
    localparam logic [RDIV_NB-1:0] RECIP_NUM = 49'd16777216;
    localparam int SQ_IN_W = 48;
    localparam int SQ_ROOT_W = 24;

    localparam logic [31:0] RST_MIN_TEMP = 32'd655;
    localparam logic [16:0] RST_TARGET = 17'd32768;
    localparam logic [15:0] RST_GROWTH = 16'd2560;
    localparam logic [15:0] RST_STEP = 16'd512;

    typedef enum logic [1:0] {
        CFG_MIN_TEMP = 2'd0,
        CFG_TARGET   = 2'd1,
        CFG_GROWTH   = 2'd2,
        CFG_STEP     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PATH_RATIO = 2'd0,
        PATH_FULL  = 2'd1,
        PATH_FLOOR = 2'd2
    } t_path;

    typedef struct packed {
        logic [31:0] weight_total;
        logic [31:0] weight_square_total;
        logic [12:0] usable_count;
        logic [31:0] current_temperature;
    } t_in;

    typedef struct packed {
        logic [31:0] next_temperature;
        logic [16:0] sample_fraction;
        logic [1:0]  path_taken;
    } t_out;

endpackage

[rtl/str_div.sv]
module str_div #(
    parameter int DW  = 17,
    parameter int NB  = 49,
    parameter int SPS = 8,
    parameter int SW  = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [NB-1:0] i_num,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NB-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int STG = (NB + SPS - 1) / SPS;

    logic          r_v    [STG];
    logic [DW-1:0] r_rem  [STG];
    logic [DW-1:0] r_den  [STG];
    logic [NB-1:0] r_num  [STG];
    logic [NB-1:0] r_quo  [STG];
    logic [SW-1:0] r_side [STG];

    logic          n_v    [STG];
    logic [DW-1:0] n_rem  [STG];
    logic [DW-1:0] n_den  [STG];
    logic [NB-1:0] n_num  [STG];
    logic [NB-1:0] n_quo  [STG];
    logic [SW-1:0] n_side [STG];

    genvar g;
    generate
        for (g = 0; g < STG; g++) begin : g_stg
            always_comb begin
                logic [DW:0] t;
                t = '0;
                if (g == 0) begin
                    n_v[g] = i_valid;
                    n_rem[g] = i_rem;
                    n_den[g] = i_den;
                    n_num[g] = i_num;
                    n_quo[g] = '0;
                    n_side[g] = i_side;
                end else begin
                    n_v[g] = r_v[g-1];
                    n_rem[g] = r_rem[g-1];
                    n_den[g] = r_den[g-1];
                    n_num[g] = r_num[g-1];
                    n_quo[g] = r_quo[g-1];
                    n_side[g] = r_side[g-1];
                end
                for (int k = 0; k < SPS; k++) begin
                    if (g * SPS + k < NB) begin
                        t = {n_rem[g], n_num[g][NB-1]};
                        n_num[g] = {n_num[g][NB-2:0], 1'b0};
                        if (t >= {1'b0, n_den[g]}) begin
                            t = t - {1'b0, n_den[g]};
                            n_quo[g] = {n_quo[g][NB-2:0], 1'b1};
                        end else begin
                            n_quo[g] = {n_quo[g][NB-2:0], 1'b0};
                        end
                        n_rem[g] = t[DW-1:0];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < STG; s++) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= n_v[s];
            end
            if (i_en) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= n_den[s];
                r_num[s] <= n_num[s];
                r_quo[s] <= n_quo[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_valid = r_v[STG-1];
    assign o_quo = r_quo[STG-1];
    assign o_side = r_side[STG-1];

endmodule

[rtl/str_sqrt.sv]
module str_sqrt #(
    parameter int SW = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [str_pkg::SQ_IN_W-1:0]     i_val,
    input  logic [SW-1:0]                   i_side,
    output logic                            o_valid,
    output logic [str_pkg::SQ_ROOT_W-1:0]   o_root,
    output logic [SW-1:0]                   o_side
);

    localparam int VW = str_pkg::SQ_IN_W;
    localparam int RW = str_pkg::SQ_ROOT_W;
    localparam int REMW = RW + 2;
    localparam int SPS = 6;
    localparam int STG = (RW + SPS - 1) / SPS;

    logic            r_v    [STG];
    logic [REMW-1:0] r_rem  [STG];
    logic [VW-1:0]   r_val  [STG];
    logic [RW-1:0]   r_root [STG];
    logic [SW-1:0]   r_side [STG];

    logic            n_v    [STG];
    logic [REMW-1:0] n_rem  [STG];
    logic [VW-1:0]   n_val  [STG];
    logic [RW-1:0]   n_root [STG];
    logic [SW-1:0]   n_side [STG];

    genvar g;
    generate
        for (g = 0; g < STG; g++) begin : g_stg
            always_comb begin
                logic [REMW+1:0] t;
                logic [REMW+1:0] trial;
                t = '0;
                trial = '0;
                if (g == 0) begin
                    n_v[g] = i_valid;
                    n_rem[g] = '0;
                    n_val[g] = i_val;
                    n_root[g] = '0;
                    n_side[g] = i_side;
                end else begin
                    n_v[g] = r_v[g-1];
                    n_rem[g] = r_rem[g-1];
                    n_val[g] = r_val[g-1];
                    n_root[g] = r_root[g-1];
                    n_side[g] = r_side[g-1];
                end
                for (int k = 0; k < SPS; k++) begin
                    if (g * SPS + k < RW) begin
                        t = {n_rem[g], n_val[g][VW-1:VW-2]};
                        trial = {2'b00, n_root[g], 2'b01};
                        n_val[g] = {n_val[g][VW-3:0], 2'b00};
                        if (t >= trial) begin
                            t = t - trial;
                            n_root[g] = {n_root[g][RW-2:0], 1'b1};
                        end else begin
                            n_root[g] = {n_root[g][RW-2:0], 1'b0};
                        end
                        n_rem[g] = t[REMW-1:0];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < STG; s++) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= n_v[s];
            end
            if (i_en) begin
                r_rem[s] <= n_rem[s];
                r_val[s] <= n_val[s];
                r_root[s] <= n_root[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_valid = r_v[STG-1];
    assign o_root = r_root[STG-1];
    assign o_side = r_side[STG-1];

endmodule

[rtl/sampling_temperature_regulator.sv]
// Sampling temperature regulator. Each input transfer (weight sum S, squared
// weight sum Q, usable count N, temperature T) yields one output transfer with
// the effective sample fraction S*S/(Q*N) in Q1.16 and the next temperature:
// the floor on a bad configuration or zero T, T times the full step when the
// fraction is zero, else T times sqrt(target/fraction) limited to the step
// bounds, clamped to [floor, floor*growth]. The pipeline takes one transfer
// per cycle unless the output stalls, which holds the whole pipeline. Its
// depth comes mostly from the 49-step ratio divider and the 24-step square
// root, both unrolled over stages. The user must write registers through the
// configuration port only while the pipeline is empty; nothing enforces this.
module sampling_temperature_regulator #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  str_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output str_pkg::t_out   o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);

    logic [31:0] r_min_temp;
    logic [16:0] r_target;
    logic [15:0] r_growth;
    logic [15:0] r_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_temp <= str_pkg::RST_MIN_TEMP;
            r_target <= str_pkg::RST_TARGET;
            r_growth <= str_pkg::RST_GROWTH;
            r_step <= str_pkg::RST_STEP;
        end else if (i_cfg_valid) begin
            case (str_pkg::t_cfg_idx'(i_cfg_index))
                str_pkg::CFG_MIN_TEMP: r_min_temp <= i_cfg_data;
                str_pkg::CFG_TARGET:   r_target <= i_cfg_data[16:0];
                str_pkg::CFG_GROWTH:   r_growth <= i_cfg_data[15:0];
                str_pkg::CFG_STEP:     r_step <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_o_v;
    str_pkg::t_out r_o;

    assign en = !r_o_v || !i_out_stall;
    assign o_in_stall = !en;

    // stage 1: square and count product
    logic [12:0] n_nsat;
    logic r1_v, r1_zero;
    logic [str_pkg::NUM_W-1:0] r1_num;
    logic [str_pkg::DEN_W-1:0] r1_den;
    logic [31:0] r1_t;

    assign n_nsat = (32'(i_in_data.usable_count) > 32'(MAX_SAMPLES))
                    ? 13'(MAX_SAMPLES) : i_in_data.usable_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
        if (en) begin
            r1_num <= 64'(i_in_data.weight_total) * 64'(i_in_data.weight_total);
            r1_den <= 45'(i_in_data.weight_square_total) * 45'(n_nsat);
            r1_zero <= (n_nsat == '0) || (i_in_data.weight_total == '0)
                       || (i_in_data.weight_square_total == '0);
            r1_t <= i_in_data.current_temperature;
        end
    end

    // stage 2: saturation check, divider setup
    logic r2_v, r2_sat, r2_zero;
    logic [str_pkg::DEN_W-1:0] r2_rem, r2_den;
    logic [15:0] r2_low;
    logic [31:0] r2_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_sat <= r1_num[63:16] >= 48'(r1_den);
            r2_rem <= r1_num[16+str_pkg::DEN_W-1:16];
            r2_low <= r1_num[15:0];
            r2_den <= r1_den;
            r2_zero <= r1_zero;
            r2_t <= r1_t;
        end
    end

    logic fd_v;
    logic [15:0] fd_q;
    logic [33:0] fd_side;

    str_div #(
        .DW(str_pkg::DEN_W), .NB(16), .SPS(4), .SW(34)
    ) u_frac_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r2_v),
        .i_rem(r2_rem), .i_den(r2_den), .i_num(r2_low),
        .i_side({r2_sat, r2_zero, r2_t}),
        .o_valid(fd_v), .o_quo(fd_q), .o_side(fd_side)
    );

    // stage 3: fraction
    logic r3_v;
    logic [16:0] r3_frac;
    logic [31:0] r3_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= fd_v;
        end
        if (en) begin
            if (fd_side[32]) begin
                r3_frac <= '0;
            end else if (fd_side[33]) begin
                r3_frac <= str_pkg::FRAC_ONE;
            end else begin
                r3_frac <= {1'b0, fd_q};
            end
            r3_t <= fd_side[31:0];
        end
    end

    logic da_v, db_v;
    logic [str_pkg::RDIV_NB-1:0] da_q, db_q;
    logic [31:0] da_side;
    logic [16:0] db_side;

    str_div #(
        .DW(str_pkg::RDIV_DW), .NB(str_pkg::RDIV_NB), .SPS(8), .SW(32)
    ) u_ratio_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r3_v),
        .i_rem('0), .i_den(r3_frac), .i_num({r_target, 32'd0}),
        .i_side(r3_t),
        .o_valid(da_v), .o_quo(da_q), .o_side(da_side)
    );

    str_div #(
        .DW(str_pkg::RDIV_DW), .NB(str_pkg::RDIV_NB), .SPS(8), .SW(17)
    ) u_recip_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r3_v),
        .i_rem('0), .i_den({1'b0, r_step}), .i_num(str_pkg::RECIP_NUM),
        .i_side(r3_frac),
        .o_valid(db_v), .o_quo(db_q), .o_side(db_side)
    );

    // stage 4: ratio saturated to the root input width
    logic r4_v;
    logic [str_pkg::SQ_IN_W-1:0] r4_ratio;
    logic [15:0] r4_lo;
    logic [16:0] r4_frac;
    logic [31:0] r4_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= da_v && db_v;
        end
        if (en) begin
            r4_ratio <= da_q[48] ? '1 : da_q[47:0];
            r4_lo <= db_q[15:0];
            r4_frac <= db_side;
            r4_t <= da_side;
        end
    end

    logic sq_v;
    logic [str_pkg::SQ_ROOT_W-1:0] sq_root;
    logic [64:0] sq_side;

    str_sqrt #(.SW(65)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r4_v),
        .i_val(r4_ratio), .i_side({r4_lo, r4_frac, r4_t}),
        .o_valid(sq_v), .o_root(sq_root), .o_side(sq_side)
    );

    // stage 5: factor limits
    logic r5_v;
    logic [23:0] r5_factor;
    logic [16:0] r5_frac;
    logic [31:0] r5_t;
    logic [23:0] n_lo, n_hi;

    assign n_lo = 24'(sq_side[64:49]);
    assign n_hi = {r_step, 8'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= sq_v;
        end
        if (en) begin
            if (sq_root < n_lo) begin
                r5_factor <= n_lo;
            end else if (sq_root > n_hi) begin
                r5_factor <= n_hi;
            end else begin
                r5_factor <= sq_root;
            end
            r5_frac <= sq_side[48:32];
            r5_t <= sq_side[31:0];
        end
    end

    // stage 6: products
    logic r6_v, r6_tz;
    logic [39:0] r6_prod, r6_full;
    logic [31:0] r6_ceil;
    logic [16:0] r6_frac;
    logic [55:0] n_prod;
    logic [47:0] n_full, n_ceil;

    assign n_prod = 56'(r5_t) * 56'(r5_factor);
    assign n_full = 48'(r5_t) * 48'(r_step);
    assign n_ceil = 48'(r_min_temp) * 48'(r_growth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
        if (en) begin
            r6_prod <= n_prod[55:16];
            r6_full <= n_full[47:8];
            r6_ceil <= (n_ceil[47:40] != '0) ? '1 : n_ceil[39:8];
            r6_frac <= r5_frac;
            r6_tz <= (r5_t == '0);
        end
    end

    // output stage: path select and clamp
    logic n_bad;
    logic [39:0] n_sel;
    logic [31:0] n_clamp;

    always_comb begin
        n_bad = (r_target == '0) || (r_growth < str_pkg::Q88_ONE)
                || (r_step <= str_pkg::Q88_ONE) || r6_tz;
        n_sel = (r6_frac == '0) ? r6_full : r6_prod;
        if (n_sel < 40'(r_min_temp)) begin
            n_clamp = r_min_temp;
        end else if (n_sel > 40'(r6_ceil)) begin
            n_clamp = r6_ceil;
        end else begin
            n_clamp = n_sel[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r6_v;
        end
        if (en) begin
            r_o.sample_fraction <= r6_frac;
            if (n_bad) begin
                r_o.next_temperature <= r_min_temp;
                r_o.path_taken <= str_pkg::PATH_FLOOR;
            end else if (r6_frac == '0) begin
                r_o.next_temperature <= n_clamp;
                r_o.path_taken <= str_pkg::PATH_FULL;
            end else begin
                r_o.next_temperature <= n_clamp;
                r_o.path_taken <= str_pkg::PATH_RATIO;
            end
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_data = r_o;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held output");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.sample_fraction <= str_pkg::FRAC_ONE))
        else $error("sample fraction above one");

    a_floor_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.path_taken == str_pkg::PATH_FLOOR)
        |-> (o_out_data.next_temperature == r_min_temp))
        else $error("floor path without floor value");

endmodule
